>>> rtl/dsa_pkg.sv
// Shared constants, codes and structs of the descriptor slot allocator.
package dsa_pkg;

  // heap geometry
  localparam int MAX_SLOTS = 1024;
  localparam int PTR_W     = $clog2(MAX_SLOTS);
  localparam int FILL_W    = $clog2(MAX_SLOTS + 1);

  // field widths
  localparam int REQ_W    = 3;
  localparam int CNT_W    = 11;
  localparam int SLOT_W   = 10;
  localparam int STRIDE_W = 9;
  localparam int ADDR_W   = 64;
  localparam int STAT_W   = 2;
  localparam int CFG_IX_W = 2;
  localparam int PROD_W   = CNT_W + STRIDE_W;

  // register reset values
  localparam logic [CNT_W-1:0]    SLOT_COUNT_RST  = CNT_W'(1024);
  localparam logic [STRIDE_W-1:0] SLOT_STRIDE_RST = STRIDE_W'(32);

  typedef enum logic [REQ_W-1:0] {
    REQ_ALLOC      = 3'd0,
    REQ_ALLOC_RUN  = 3'd1,
    REQ_ALLOC_BUMP = 3'd2,
    REQ_FREE       = 3'd3,
    REQ_RESET      = 3'd4
  } req_type_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_EXHAUSTED = 2'd1,
    ST_BAD_INDEX = 2'd2,
    ST_LIST_FULL = 2'd3
  } status_t;

  typedef enum logic [CFG_IX_W-1:0] {
    CFG_SLOT_COUNT  = 2'd0,
    CFG_SLOT_STRIDE = 2'd1,
    CFG_HOST_BASE   = 2'd2,
    CFG_DEVICE_BASE = 2'd3
  } cfg_index_t;

  // free queue RAM access for one cycle
  typedef struct packed {
    logic              wr_en;
    logic [PTR_W-1:0]  wr_addr;
    logic [SLOT_W-1:0] wr_data;
    logic              rd_en;
    logic [PTR_W-1:0]  rd_addr;
  } ram_req_t;

  // decision taken at the input transfer
  typedef struct packed {
    logic [CNT_W-1:0] slot;
    logic             from_queue;
    logic             addr_en;
    status_t          status;
    logic [CNT_W-1:0] fresh;
  } decision_t;

endpackage

>>> rtl/dsa_queue_ram.sv
// Free list storage: one write port, one registered read port.
module dsa_queue_ram (
  input  logic                        clk,
  input  dsa_pkg::ram_req_t           req,
  output logic [dsa_pkg::SLOT_W-1:0]  rd_data
);

  logic [dsa_pkg::SLOT_W-1:0] mem [dsa_pkg::MAX_SLOTS];
  logic [dsa_pkg::SLOT_W-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data_r <= mem[req.rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> rtl/descriptor_slot_allocator_top.sv
// Top level of the descriptor slot allocator: request decode, free list control, address pipe.
//
// Requests arrive on the in_ channel (valid/ready), one result per request leaves on the
// out_ channel (valid/ready). Registers are written on the cfg_ channel, which is ready
// whenever reset is released; write them only while no request is in flight.
// A request is decided in the cycle of its transfer: bump pointer and free list pointers
// move at that edge, and the free list RAM is read at the old head.
// Stage two picks the slot (RAM data or the slot from the decision) and forms slot times stride.
// Stage three adds the host and device bases into the output register.
// An accepted request passes the stage one, stage two and output registers. Throughput: one
// request per cycle unless the receiver stalls; pointer and fill registers update at each transfer.
// Reset (rst_n low, synchronous) empties the pipe and free list, rewinds the bump pointer
// and restores the registers to slot_count 1024, stride 32 and both bases zero.
// The free list RAM content is not cleared; entries are read only after being written.
// When the receiver stalls, each stage holds its item and closes up bubbles; in_ready
// falls once all three stages hold results.
module descriptor_slot_allocator_top (
  input  logic                          clk,
  input  logic                          rst_n,
  // request channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [dsa_pkg::REQ_W-1:0]     in_req_type,
  input  logic [dsa_pkg::CNT_W-1:0]     in_run_length,
  input  logic [dsa_pkg::SLOT_W-1:0]    in_slot_in,
  // result channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [dsa_pkg::SLOT_W-1:0]    out_slot_out,
  output logic [dsa_pkg::ADDR_W-1:0]    out_host_addr,
  output logic [dsa_pkg::ADDR_W-1:0]    out_device_addr,
  output logic [dsa_pkg::STAT_W-1:0]    out_status,
  output logic [dsa_pkg::CNT_W-1:0]     out_next_fresh,
  // configuration channel
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [dsa_pkg::CFG_IX_W-1:0]  cfg_index,
  input  logic [dsa_pkg::ADDR_W-1:0]    cfg_data
);

  // configuration registers
  logic [dsa_pkg::CNT_W-1:0]    slot_count_r;
  logic [dsa_pkg::STRIDE_W-1:0] slot_stride_r;
  logic [dsa_pkg::ADDR_W-1:0]   host_base_r;
  logic [dsa_pkg::ADDR_W-1:0]   device_base_r;

  // allocator state
  logic [dsa_pkg::CNT_W-1:0]  bump_r,  bump_nxt;
  logic [dsa_pkg::PTR_W-1:0]  head_r,  head_nxt;
  logic [dsa_pkg::PTR_W-1:0]  tail_r,  tail_nxt;
  logic [dsa_pkg::FILL_W-1:0] fill_r,  fill_nxt;

  // pipe control
  logic s1_v_r, s2_v_r, out_v_r;
  logic out_free, s2_free, s1_free, in_xfer;

  dsa_pkg::decision_t dec_nxt, s1_r;
  dsa_pkg::ram_req_t  ram_req;
  logic [dsa_pkg::SLOT_W-1:0] ram_rd;

  logic [dsa_pkg::CNT_W-1:0]    cap;
  logic [dsa_pkg::CNT_W:0]      run_end;
  logic                         queue_full;
  logic [dsa_pkg::CNT_W-1:0]    s2_slot_sel;

  // stage two registers
  logic [dsa_pkg::SLOT_W-1:0] s2_slot_r;
  logic [dsa_pkg::PROD_W-1:0] s2_off_r;
  logic                       s2_addr_en_r;
  dsa_pkg::status_t           s2_status_r;
  logic [dsa_pkg::CNT_W-1:0]  s2_fresh_r;

  // output registers
  logic [dsa_pkg::SLOT_W-1:0] out_slot_r;
  logic [dsa_pkg::ADDR_W-1:0] out_host_r;
  logic [dsa_pkg::ADDR_W-1:0] out_dev_r;
  dsa_pkg::status_t           out_status_r;
  logic [dsa_pkg::CNT_W-1:0]  out_fresh_r;

  // ready chain from the output backwards; nothing is taken during reset
  assign out_free = !out_v_r || out_ready;
  assign s2_free  = !s2_v_r || out_free;
  assign s1_free  = !s1_v_r || s2_free;
  assign in_ready = s1_free && rst_n;
  assign in_xfer  = in_valid && in_ready;
  assign cfg_ready = rst_n;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_count_r  <= dsa_pkg::SLOT_COUNT_RST;
      slot_stride_r <= dsa_pkg::SLOT_STRIDE_RST;
      host_base_r   <= '0;
      device_base_r <= '0;
    end else if (cfg_valid) begin
      unique case (dsa_pkg::cfg_index_t'(cfg_index))
        dsa_pkg::CFG_SLOT_COUNT:  slot_count_r  <= cfg_data[dsa_pkg::CNT_W-1:0];
        dsa_pkg::CFG_SLOT_STRIDE: slot_stride_r <= cfg_data[dsa_pkg::STRIDE_W-1:0];
        dsa_pkg::CFG_HOST_BASE:   host_base_r   <= cfg_data;
        dsa_pkg::CFG_DEVICE_BASE: device_base_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // usable capacity saturates at the heap size
  assign cap = (slot_count_r < dsa_pkg::CNT_W'(dsa_pkg::MAX_SLOTS))
             ? slot_count_r : dsa_pkg::CNT_W'(dsa_pkg::MAX_SLOTS);
  assign run_end    = {1'b0, bump_r} + {1'b0, in_run_length};
  assign queue_full = (fill_r >= dsa_pkg::FILL_W'(dsa_pkg::MAX_SLOTS));

  // request decode and state update
  always_comb begin
    bump_nxt = bump_r;
    head_nxt = head_r;
    tail_nxt = tail_r;
    fill_nxt = fill_r;
    dec_nxt.slot       = '0;
    dec_nxt.from_queue = 1'b0;
    dec_nxt.addr_en    = 1'b0;
    dec_nxt.status     = dsa_pkg::ST_OK;
    ram_req.wr_en   = 1'b0;
    ram_req.wr_addr = tail_r;
    ram_req.wr_data = in_slot_in;
    ram_req.rd_en   = 1'b0;
    ram_req.rd_addr = head_r;

    unique case (dsa_pkg::req_type_t'(in_req_type))
      dsa_pkg::REQ_ALLOC, dsa_pkg::REQ_ALLOC_BUMP: begin
        if ((dsa_pkg::req_type_t'(in_req_type) == dsa_pkg::REQ_ALLOC) && (fill_r != '0)) begin
          // reuse the oldest freed slot
          dec_nxt.from_queue = 1'b1;
          dec_nxt.addr_en    = 1'b1;
          ram_req.rd_en      = in_xfer;
          head_nxt = (head_r == dsa_pkg::PTR_W'(dsa_pkg::MAX_SLOTS - 1)) ? '0 : head_r + 1'b1;
          fill_nxt = fill_r - 1'b1;
        end else if (bump_r >= cap) begin
          dec_nxt.status = dsa_pkg::ST_EXHAUSTED;
        end else begin
          dec_nxt.slot    = bump_r;
          dec_nxt.addr_en = 1'b1;
          bump_nxt        = bump_r + 1'b1;
        end
      end
      dsa_pkg::REQ_ALLOC_RUN: begin
        if (run_end > {1'b0, cap}) begin
          dec_nxt.status = dsa_pkg::ST_EXHAUSTED;
        end else begin
          dec_nxt.slot    = bump_r;
          dec_nxt.addr_en = 1'b1;
          bump_nxt        = run_end[dsa_pkg::CNT_W-1:0];
        end
      end
      dsa_pkg::REQ_FREE: begin
        dec_nxt.slot = {1'b0, in_slot_in};
        if ({1'b0, in_slot_in} >= cap) begin
          dec_nxt.status = dsa_pkg::ST_BAD_INDEX;
        end else if (queue_full) begin
          dec_nxt.status = dsa_pkg::ST_LIST_FULL;
        end else begin
          ram_req.wr_en = in_xfer;
          tail_nxt = (tail_r == dsa_pkg::PTR_W'(dsa_pkg::MAX_SLOTS - 1)) ? '0 : tail_r + 1'b1;
          fill_nxt = fill_r + 1'b1;
        end
      end
      dsa_pkg::REQ_RESET: begin
        bump_nxt = '0;
        head_nxt = '0;
        tail_nxt = '0;
        fill_nxt = '0;
      end
      default: ;
    endcase
    dec_nxt.fresh = bump_nxt;
  end

  // free list RAM
  dsa_queue_ram u_queue_ram (
    .clk     (clk),
    .req     (ram_req),
    .rd_data (ram_rd)
  );

  // state registers move on each input transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bump_r <= '0;
      head_r <= '0;
      tail_r <= '0;
      fill_r <= '0;
    end else if (in_xfer) begin
      bump_r <= bump_nxt;
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      fill_r <= fill_nxt;
    end
  end

  // stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (s1_free) begin
        s1_v_r <= in_valid;
      end
      if (s2_free) begin
        s2_v_r <= s1_v_r;
      end
      if (out_free) begin
        out_v_r <= s2_v_r;
      end
    end
  end

  // stage one: decision
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_r <= dec_nxt;
    end
  end

  // stage two: slot select and offset
  assign s2_slot_sel = s1_r.from_queue ? {1'b0, ram_rd} : s1_r.slot;

  always_ff @(posedge clk) begin
    if (s1_v_r && s2_free) begin
      s2_slot_r    <= s2_slot_sel[dsa_pkg::SLOT_W-1:0];
      s2_off_r     <= dsa_pkg::PROD_W'(s2_slot_sel) * dsa_pkg::PROD_W'(slot_stride_r);
      s2_addr_en_r <= s1_r.addr_en;
      s2_status_r  <= s1_r.status;
      s2_fresh_r   <= s1_r.fresh;
    end
  end

  // stage three: base addition into the output register
  always_ff @(posedge clk) begin
    if (s2_v_r && out_free) begin
      out_slot_r   <= s2_slot_r;
      out_host_r   <= s2_addr_en_r
                    ? host_base_r + dsa_pkg::ADDR_W'(s2_off_r) : '0;
      out_dev_r    <= s2_addr_en_r
                    ? device_base_r + dsa_pkg::ADDR_W'(s2_off_r) : '0;
      out_status_r <= s2_status_r;
      out_fresh_r  <= s2_fresh_r;
    end
  end

  assign out_valid       = out_v_r;
  assign out_slot_out    = out_slot_r;
  assign out_host_addr   = out_host_r;
  assign out_device_addr = out_dev_r;
  assign out_status      = out_status_r;
  assign out_next_fresh  = out_fresh_r;

  // checks
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= dsa_pkg::FILL_W'(dsa_pkg::MAX_SLOTS))
    else $error("free list fill above heap size");

  a_ptr_match: assert property (@(posedge clk) disable iff (!rst_n)
    (fill_r == '0 || fill_r == dsa_pkg::FILL_W'(dsa_pkg::MAX_SLOTS)) |-> head_r == tail_r)
    else $error("free list pointers disagree with fill");

  a_bump_bound: assert property (@(posedge clk) disable iff (!rst_n)
    bump_r <= dsa_pkg::CNT_W'(dsa_pkg::MAX_SLOTS))
    else $error("bump pointer beyond heap");

  a_reset_req: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && in_req_type == dsa_pkg::REQ_RESET) |=> (bump_r == '0 && fill_r == '0))
    else $error("reset request left state behind");

  a_s2_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_v_r && !out_free) |=> s2_v_r)
    else $error("stage two item lost under stall");

endmodule
